@@ src/ssfh_pkg.sv @@
// Shared constants, widths and the command record for the slit-scan frame history.
// No dependencies; every other file of the block imports this package.
package ssfh_pkg;

    localparam int HISTORY_DEPTH = 80;
    localparam int MAX_WIDTH     = 640;
    localparam int MAX_HEIGHT    = 480;

    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int COLOR_W = 8;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int IDX_W   = 7;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'd1;
    localparam logic [X_W-1:0] RST_ACTIVE_WIDTH  = 10'd640;
    localparam logic [Y_W-1:0] RST_ACTIVE_HEIGHT = 9'd480;

    localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int PROD_W     = Y_W + CNT_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int ROW_DEPTH  = HISTORY_DEPTH * MAX_HEIGHT;
    localparam int ROW_W      = $clog2(ROW_DEPTH);
    localparam int STORE_DEPTH = HISTORY_DEPTH * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic              in_range;
        logic [CNT_W-1:0]  held;
        logic [SLOT_W-1:0] oldest;
        logic [X_W-1:0]    pos_x;
        logic [Y_W-1:0]    pos_y;
        logic [PROD_W-1:0] product;
        logic [Y_W-1:0]    divisor;
        logic [PIX_W-1:0]  pix;
    } t_cmd;

endpackage

@@ src/ssfh_front.sv @@
// Front end: accepts pixels, tracks the frame ring bookkeeping and classifies each pixel.
// Depends on ssfh_pkg; feeds the command queue.
module ssfh_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic                     i_q_full,
    input  logic                     i_frame_start,
    input  logic [ssfh_pkg::X_W-1:0] i_pos_x,
    input  logic [ssfh_pkg::Y_W-1:0] i_pos_y,
    input  logic [ssfh_pkg::PIX_W-1:0] i_pix,
    input  logic [ssfh_pkg::X_W-1:0] i_act_w,
    input  logic [ssfh_pkg::Y_W-1:0] i_act_h,
    output logic                     o_q_push,
    output ssfh_pkg::t_cmd           o_cmd
);
    import ssfh_pkg::*;

    logic [CNT_W-1:0]  r_held, n_held;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [X_W-1:0]    eff_w;
    logic [Y_W-1:0]    eff_h;
    logic              accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    always_comb begin
        eff_w = (32'(i_act_w) < MAX_WIDTH) ? i_act_w : X_W'(MAX_WIDTH);
        eff_h = (32'(i_act_h) < MAX_HEIGHT) ? i_act_h : Y_W'(MAX_HEIGHT);
    end

    // open a new frame: grow the ring until full, then retire the oldest slot
    always_comb begin
        n_held   = r_held;
        n_oldest = r_oldest;
        if (i_frame_start) begin
            if (32'(r_held) < HISTORY_DEPTH) begin
                n_held = r_held + CNT_W'(1);
            end else if (32'(r_oldest) == HISTORY_DEPTH - 1) begin
                n_oldest = '0;
            end else begin
                n_oldest = r_oldest + SLOT_W'(1);
            end
        end
    end

    always_comb begin
        o_cmd.in_range = (i_pos_x < eff_w) && (i_pos_y < eff_h) && (n_held != '0);
        o_cmd.held     = n_held;
        o_cmd.oldest   = n_oldest;
        o_cmd.pos_x    = i_pos_x;
        o_cmd.pos_y    = i_pos_y;
        o_cmd.product  = PROD_W'(i_pos_y) * PROD_W'(n_held);
        o_cmd.divisor  = eff_h;
        o_cmd.pix      = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_oldest <= '0;
        end else if (accept) begin
            r_held   <= n_held;
            r_oldest <= n_oldest;
        end
    end

endmodule

@@ src/ssfh_cmd_queue.sv @@
// Short queue of classified pixel commands between the front and back ends.
// Depends on ssfh_pkg for the command record and depth.
module ssfh_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssfh_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output ssfh_pkg::t_cmd o_data,
    output logic           o_empty
);
    import ssfh_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (32'(r_count) == CMDQ_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == CMDQ_DEPTH - 1) ? '0 : r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == CMDQ_DEPTH - 1) ? '0 : r_rd_ptr + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

@@ src/ssfh_back.sv @@
// Back end: row to frame division, ring slot and address math, frame store, result register.
// Depends on ssfh_pkg; pops commands from the command queue.
module ssfh_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssfh_pkg::t_cmd               i_cmd,
    input  logic                         i_cmd_empty,
    output logic                         o_cmd_pop,
    output logic [ssfh_pkg::PIX_W-1:0]   o_pix,
    output logic [ssfh_pkg::IDX_W-1:0]   o_idx,
    output logic                         o_empty,
    input  logic                         i_pop
);
    import ssfh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SLOT = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_ADDR = 3'd4;
    localparam logic [2:0] S_MEM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           r_state, n_state;
    t_cmd                 r_cmd;
    logic [Y_W-1:0]       r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]    r_rd_slot;
    logic [SLOT_W-1:0]    r_wr_slot;
    logic                 r_need_rd;
    logic [ROW_W-1:0]     r_rd_row;
    logic [ROW_W-1:0]     r_wr_row;
    logic [ADDR_W-1:0]    r_rd_addr;
    logic [ADDR_W-1:0]    r_wr_addr;
    logic [PIX_W-1:0]     r_rd_data;
    logic [PIX_W-1:0]     r_store [STORE_DEPTH];
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pix;
    logic [CNT_W-1:0]     r_out_idx;

    logic [Y_W:0]         rem_sh;
    logic                 rem_ge;
    logic [CNT_W-1:0]     newest;
    logic [CNT_W-1:0]     idx_sel;
    logic                 out_free;

    function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] base,
                                                     input logic [CNT_W-1:0]  age);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(age);
        if (32'(sum) >= HISTORY_DEPTH) begin
            sum = sum - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign out_free  = !r_out_valid || i_pop;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_quo[PROD_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_cmd.divisor});
    end

    always_comb begin
        newest = r_cmd.held - CNT_W'(1);
        if (r_cmd.in_range) begin
            idx_sel = (r_quo > PROD_W'(newest)) ? newest : r_quo[CNT_W-1:0];
        end else if (r_cmd.held == '0) begin
            idx_sel = '0;
        end else begin
            idx_sel = newest;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_cmd_empty) n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_SLOT;
            S_SLOT: n_state = S_ROW;
            S_ROW:  n_state = S_ADDR;
            S_ADDR: n_state = S_MEM;
            S_MEM:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_rem <= '0;
                r_quo <= i_cmd.product;
                r_cnt <= DIV_CNT_W'(PROD_W - 1);
            end
            S_DIV: begin
                r_rem <= rem_ge ? Y_W'(rem_sh - {1'b0, r_cmd.divisor}) : Y_W'(rem_sh);
                r_quo <= {r_quo[PROD_W-2:0], rem_ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
            S_SLOT: begin
                r_idx     <= idx_sel;
                r_need_rd <= r_cmd.in_range && (idx_sel != newest);
                r_rd_slot <= ring_slot(r_cmd.oldest, idx_sel);
                r_wr_slot <= ring_slot(r_cmd.oldest, newest);
            end
            S_ROW: begin
                r_rd_row <= ROW_W'(r_rd_slot) * ROW_W'(MAX_HEIGHT) + ROW_W'(r_cmd.pos_y);
                r_wr_row <= ROW_W'(r_wr_slot) * ROW_W'(MAX_HEIGHT) + ROW_W'(r_cmd.pos_y);
            end
            S_ADDR: begin
                r_rd_addr <= ADDR_W'(r_rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_cmd.pos_x);
                r_wr_addr <= ADDR_W'(r_wr_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_cmd.pos_x);
            end
            default: begin
            end
        endcase
    end

    // frame store: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (r_state == S_MEM) begin
            if (r_need_rd) begin
                r_rd_data <= r_store[r_rd_addr];
            end
            if (r_cmd.in_range) begin
                r_store[r_wr_addr] <= r_cmd.pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_pix <= r_need_rd ? r_rd_data : r_cmd.pix;
            r_out_idx <= r_idx;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_pix   = r_out_pix;
    assign o_idx   = IDX_W'(r_out_idx);

endmodule

@@ src/slit_scan_frame_history_unit.sv @@
// Slit-scan frame history: each pixel of a raster stream is replaced by the pixel at the same
// place in a past frame chosen by its row (row times frames held, over the frame height; 0 is
// the oldest frame). A ring of 80 frames of 640x480 RGB pixels keeps the history; each frame
// start opens a new frame and, once the ring is full, overwrites the oldest. When the chosen
// frame is the one being written, or before the first frame start, or for a pixel outside the
// active size, the input pixel passes through. The back end works on one pixel at a time, in
// turn through the bit-per-cycle row to frame division, slot, row and address math, store access
// and result load; a two-entry command queue lets the front keep taking pixels during that time.
// The frame store holds whatever it held until a position is written; there is no clearing pass
// after reset.
// Depends on ssfh_pkg, ssfh_front, ssfh_cmd_queue and ssfh_back.
module slit_scan_frame_history_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_frame_start,
    input  logic [ssfh_pkg::X_W-1:0]           i_pos_x,
    input  logic [ssfh_pkg::Y_W-1:0]           i_pos_y,
    input  logic [ssfh_pkg::COLOR_W-1:0]       i_in_red,
    input  logic [ssfh_pkg::COLOR_W-1:0]       i_in_green,
    input  logic [ssfh_pkg::COLOR_W-1:0]       i_in_blue,
    output logic                               empty,
    input  logic                               pop,
    output logic [ssfh_pkg::COLOR_W-1:0]       o_out_red,
    output logic [ssfh_pkg::COLOR_W-1:0]       o_out_green,
    output logic [ssfh_pkg::COLOR_W-1:0]       o_out_blue,
    output logic [ssfh_pkg::IDX_W-1:0]         o_history_index,
    input  logic                               i_cfg_we,
    input  logic [ssfh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssfh_pkg::CFG_W-1:0]         i_cfg_data
);
    import ssfh_pkg::*;

    logic [X_W-1:0]   r_act_w;
    logic [Y_W-1:0]   r_act_h;
    t_cmd             front_cmd;
    t_cmd             back_cmd;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic [PIX_W-1:0] out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w <= RST_ACTIVE_WIDTH;
            r_act_h <= RST_ACTIVE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_WIDTH:  r_act_w <= i_cfg_data[X_W-1:0];
                CFG_ACTIVE_HEIGHT: r_act_h <= i_cfg_data[Y_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssfh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_q_full      (full),
        .i_frame_start (i_frame_start),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pix         ({i_in_red, i_in_green, i_in_blue}),
        .i_act_w       (r_act_w),
        .i_act_h       (r_act_h),
        .o_q_push      (q_push),
        .o_cmd         (front_cmd)
    );

    ssfh_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (back_cmd),
        .o_empty (q_empty)
    );

    ssfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_pix       (out_pix),
        .o_idx       (o_history_index),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_out_red   = out_pix[PIX_W-1 -: COLOR_W];
    assign o_out_green = out_pix[2*COLOR_W-1 -: COLOR_W];
    assign o_out_blue  = out_pix[COLOR_W-1:0];

endmodule
